// File: sv/pifa_pkg.sv
// Package for the PI controller with feedforward and anti-windup clamping.
// Holds field widths, register and microcode codes, the control store and
// saturation helpers. No dependencies.
package pifa_pkg;

    localparam int LUX_W      = 16;
    localparam int ERR_W      = 17;
    localparam int DUTY_W     = 15;
    localparam int DRIVE_W    = 32;
    localparam int KP_W       = 16;
    localparam int KI_W       = 24;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DUTY_FULL  = 25600;
    localparam int LPP_RESET  = 256;
    localparam int MODE_RESET = 3;

    // Mode flag bit positions
    localparam int MODE_FB  = 0;
    localparam int MODE_FF  = 1;
    localparam int MODE_AW  = 2;
    localparam int MODE_OCC = 3;

    // Fixed-point shifts
    localparam int I_SHIFT  = 14;
    localparam int P_SHIFT  = 6;
    localparam int FF_SHIFT = 10;

    // Datapath widths
    localparam int WIDE_W   = KI_W + 1 + ERR_W;     // full product width
    localparam int P_W      = 28;                   // shifted P term
    localparam int U_W      = 34;                   // drive sums and bounds
    localparam int DIV_BITS = LUX_W + FF_SHIFT;     // quotient bits
    localparam int CNT_W    = $clog2(DIV_BITS + 1);

    localparam logic signed [U_W-1:0] FULL_U = U_W'(DUTY_FULL);
    localparam logic signed [WIDE_W-1:0] S32_MAX =
        {{(WIDE_W - DRIVE_W + 1){1'b0}}, {(DRIVE_W - 1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] S32_MIN =
        {{(WIDE_W - DRIVE_W + 1){1'b1}}, {(DRIVE_W - 1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_REF_OCC     = 3'd2,
        CFG_REF_UNOCC   = 3'd3,
        CFG_BACKGROUND  = 3'd4,
        CFG_LUX_PER_PCT = 3'd5,
        CFG_MODE_FLAGS  = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_I,
        OP_ACC_I,
        OP_MUL_P,
        OP_SHIFT_P,
        OP_FB_SUM,
        OP_FF_SETUP,
        OP_DIV_STEP,
        OP_FF_CLAMP,
        OP_SUM,
        OP_AW_BOUND,
        OP_AW_CLAMP,
        OP_RESUM,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_IN_WAIT,
        COND_FF_DIRECT,
        COND_DIV_LOOP,
        COND_AW_SKIP,
        COND_OUT_WAIT
    } t_cond;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    localparam t_pc STEP_IDLE     = 4'd0;
    localparam t_pc STEP_MUL_I    = 4'd1;
    localparam t_pc STEP_ACC_I    = 4'd2;
    localparam t_pc STEP_MUL_P    = 4'd3;
    localparam t_pc STEP_SHIFT_P  = 4'd4;
    localparam t_pc STEP_FB_SUM   = 4'd5;
    localparam t_pc STEP_FF_SETUP = 4'd6;
    localparam t_pc STEP_DIV      = 4'd7;
    localparam t_pc STEP_FF_CLAMP = 4'd8;
    localparam t_pc STEP_SUM      = 4'd9;
    localparam t_pc STEP_AW_BOUND = 4'd10;
    localparam t_pc STEP_AW_CLAMP = 4'd11;
    localparam t_pc STEP_FB_AGAIN = 4'd12;
    localparam t_pc STEP_RESUM    = 4'd13;
    localparam t_pc STEP_OUT      = 4'd14;

    // Control store: one control word per step
    function automatic t_ctrl ucode_rom(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_IN_WAIT,   target: STEP_IDLE};
            STEP_MUL_I:    w = '{op: OP_MUL_I,    cond: COND_NEXT,      target: STEP_IDLE};
            STEP_ACC_I:    w = '{op: OP_ACC_I,    cond: COND_NEXT,      target: STEP_IDLE};
            STEP_MUL_P:    w = '{op: OP_MUL_P,    cond: COND_NEXT,      target: STEP_IDLE};
            STEP_SHIFT_P:  w = '{op: OP_SHIFT_P,  cond: COND_NEXT,      target: STEP_IDLE};
            STEP_FB_SUM:   w = '{op: OP_FB_SUM,   cond: COND_NEXT,      target: STEP_IDLE};
            STEP_FF_SETUP: w = '{op: OP_FF_SETUP, cond: COND_FF_DIRECT, target: STEP_SUM};
            STEP_DIV:      w = '{op: OP_DIV_STEP, cond: COND_DIV_LOOP,  target: STEP_DIV};
            STEP_FF_CLAMP: w = '{op: OP_FF_CLAMP, cond: COND_NEXT,      target: STEP_IDLE};
            STEP_SUM:      w = '{op: OP_SUM,      cond: COND_NEXT,      target: STEP_IDLE};
            STEP_AW_BOUND: w = '{op: OP_AW_BOUND, cond: COND_AW_SKIP,   target: STEP_OUT};
            STEP_AW_CLAMP: w = '{op: OP_AW_CLAMP, cond: COND_NEXT,      target: STEP_IDLE};
            STEP_FB_AGAIN: w = '{op: OP_FB_SUM,   cond: COND_NEXT,      target: STEP_IDLE};
            STEP_RESUM:    w = '{op: OP_RESUM,    cond: COND_NEXT,      target: STEP_IDLE};
            STEP_OUT:      w = '{op: OP_EMIT,     cond: COND_OUT_WAIT,  target: STEP_IDLE};
            default:       w = '{op: OP_NOP,      cond: COND_NEXT,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // Saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [DRIVE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v > S32_MAX) begin
            r = DRIVE_W'(S32_MAX);
        end else if (v < S32_MIN) begin
            r = DRIVE_W'(S32_MIN);
        end else begin
            r = DRIVE_W'(v);
        end
        return r;
    endfunction

endpackage

// File: sv/pifa_in_if.sv
// Input channel of the PI controller: valid/ready plus the two lux samples.
// Depends on pifa_pkg for field widths.
interface pifa_in_if;
    import pifa_pkg::*;

    logic             valid;
    logic             ready;
    logic [LUX_W-1:0] measured_lux;
    logic [LUX_W-1:0] predicted_lux;

    modport source (output valid, output measured_lux, output predicted_lux, input ready);
    modport sink   (input valid, input measured_lux, input predicted_lux, output ready);
endinterface

// File: sv/pifa_out_if.sv
// Result channel of the PI controller: valid/ready plus the result fields.
// Depends on pifa_pkg for field widths.
interface pifa_out_if;
    import pifa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DUTY_W-1:0]         duty_out;
    logic signed [ERR_W-1:0]   error_value;
    logic signed [DRIVE_W-1:0] feedback_drive;
    logic [DUTY_W-1:0]         feedforward_drive;
    logic signed [DRIVE_W-1:0] integral_value;
    logic                      was_saturated;

    modport source (output valid, output duty_out, output error_value,
                    output feedback_drive, output feedforward_drive,
                    output integral_value, output was_saturated, input ready);
    modport sink   (input valid, input duty_out, input error_value,
                    input feedback_drive, input feedforward_drive,
                    input integral_value, input was_saturated, output ready);
endinterface

// File: sv/pi_feedforward_antiwindup_ctrl.sv
// A transaction passes the 26-step restoring divider for the feedforward term, which is skipped
// when the feedforward needs no division (reference at or below background, or zero plant
// gain); the anti-windup clamp adds its own steps. One transaction is in the sequencer at a
// time; a new input is taken while the result register still waits. Reset (synchronous,
// active low) clears the integral, the step counter, the result valid and loads the
// register reset values; no clearing pass.
//
// Top level of the PI controller with feedforward and anti-windup clamping.
// Depends on pifa_pkg, pifa_in_if and pifa_out_if.
module pi_feedforward_antiwindup_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pifa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pifa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pifa_in_if.sink                             i_in,
    pifa_out_if.source                          o_out
);
    import pifa_pkg::*;

    // Configuration registers
    logic [KP_W-1:0]   r_kp;
    logic [KI_W-1:0]   r_ki;
    logic [LUX_W-1:0]  r_ref_occ;
    logic [LUX_W-1:0]  r_ref_unocc;
    logic [LUX_W-1:0]  r_bg;
    logic [LUX_W-1:0]  r_lpp;
    logic [MODE_W-1:0] r_mode;

    // Sequencer
    t_pc   r_pc, n_pc;
    t_ctrl w_ctrl;

    // Datapath registers
    logic signed [ERR_W-1:0]   r_e, n_e;
    logic signed [WIDE_W-1:0]  r_prod, n_prod;
    logic signed [DRIVE_W-1:0] r_integ, n_integ;
    logic signed [P_W-1:0]     r_p, n_p;
    logic signed [DRIVE_W-1:0] r_ufb, n_ufb;
    logic [DUTY_W-1:0]         r_uff, n_uff;
    logic [DIV_BITS-1:0]       r_quo, n_quo;
    logic [LUX_W-1:0]          r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [U_W-1:0]     r_u, n_u;
    logic                      r_sat, n_sat;
    logic signed [U_W-1:0]     r_bound, n_bound;
    logic                      r_hi, n_hi;

    // Result register
    logic                      r_out_valid, n_out_valid;
    logic [DUTY_W-1:0]         r_o_duty, n_o_duty;
    logic signed [ERR_W-1:0]   r_o_err, n_o_err;
    logic signed [DRIVE_W-1:0] r_o_fb, n_o_fb;
    logic [DUTY_W-1:0]         r_o_ff, n_o_ff;
    logic signed [DRIVE_W-1:0] r_o_integ, n_o_integ;
    logic                      r_o_sat, n_o_sat;

    // Helper values
    logic                      w_in_take;
    logic                      w_out_free;
    logic [LUX_W-1:0]          w_ref;
    logic signed [LUX_W:0]     w_diff;
    logic                      w_ff_direct;
    logic [LUX_W:0]            w_trial;
    logic                      w_trial_ge;
    logic [DUTY_W-1:0]         w_ff_used;
    logic signed [U_W-1:0]     w_ff_s;
    logic signed [U_W-1:0]     w_fb_s;
    logic signed [U_W-1:0]     w_p_s;
    logic signed [U_W-1:0]     w_integ_s;
    logic signed [U_W-1:0]     w_sum;
    logic                      w_sum_sat;
    logic                      w_aw_active;

    assign w_ctrl     = ucode_rom(r_pc);
    assign i_in.ready = (r_pc == STEP_IDLE);
    assign w_in_take  = i_in.valid && (r_pc == STEP_IDLE);
    // Result register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || o_out.ready;

    assign o_out.valid             = r_out_valid;
    assign o_out.duty_out          = r_o_duty;
    assign o_out.error_value       = r_o_err;
    assign o_out.feedback_drive    = r_o_fb;
    assign o_out.feedforward_drive = r_o_ff;
    assign o_out.integral_value    = r_o_integ;
    assign o_out.was_saturated     = r_o_sat;

    // Feedforward setup: reference minus background
    assign w_ref       = r_mode[MODE_OCC] ? r_ref_occ : r_ref_unocc;
    assign w_diff      = signed'({1'b0, w_ref}) - signed'({1'b0, r_bg});
    assign w_ff_direct = (w_diff <= 0) || (r_lpp == '0);

    // One restoring division step: shift in the next dividend bit, trial subtract
    assign w_trial    = {r_rem, r_quo[DIV_BITS-1]};
    assign w_trial_ge = (w_trial >= {1'b0, r_lpp});

    // Branch sum; feedforward counts only when its branch is on
    assign w_ff_used   = r_mode[MODE_FF] ? r_uff : '0;
    assign w_ff_s      = U_W'(signed'({1'b0, w_ff_used}));
    assign w_fb_s      = r_mode[MODE_FB] ? U_W'(r_ufb) : '0;
    assign w_p_s       = U_W'(r_p);
    assign w_integ_s   = U_W'(r_integ);
    assign w_sum       = w_fb_s + w_ff_s;
    assign w_sum_sat   = (w_sum > FULL_U) || (w_sum < 0);
    assign w_aw_active = r_mode[MODE_AW] && r_sat && (r_ki != '0);

    // Next step
    always_comb begin
        n_pc = r_pc + t_pc'(1);
        case (w_ctrl.cond)
            COND_NEXT: begin
                n_pc = r_pc + t_pc'(1);
            end
            COND_IN_WAIT: begin
                n_pc = w_in_take ? r_pc + t_pc'(1) : r_pc;
            end
            COND_FF_DIRECT: begin
                n_pc = w_ff_direct ? w_ctrl.target : r_pc + t_pc'(1);
            end
            COND_DIV_LOOP: begin
                // repeat until the last quotient bit is in
                n_pc = (r_cnt != CNT_W'(1)) ? w_ctrl.target : r_pc + t_pc'(1);
            end
            COND_AW_SKIP: begin
                n_pc = w_aw_active ? r_pc + t_pc'(1) : w_ctrl.target;
            end
            COND_OUT_WAIT: begin
                // hold the finished transaction until the result register frees
                n_pc = w_out_free ? w_ctrl.target : r_pc;
            end
            default: begin
                n_pc = STEP_IDLE;
            end
        endcase
    end

    // Datapath, driven by the current control word
    always_comb begin
        n_e         = r_e;
        n_prod      = r_prod;
        n_integ     = r_integ;
        n_p         = r_p;
        n_ufb       = r_ufb;
        n_uff       = r_uff;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_u         = r_u;
        n_sat       = r_sat;
        n_bound     = r_bound;
        n_hi        = r_hi;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_duty    = r_o_duty;
        n_o_err     = r_o_err;
        n_o_fb      = r_o_fb;
        n_o_ff      = r_o_ff;
        n_o_integ   = r_o_integ;
        n_o_sat     = r_o_sat;
        case (w_ctrl.op)
            OP_LOAD: begin
                if (w_in_take) begin
                    n_e = signed'({1'b0, i_in.predicted_lux})
                        - signed'({1'b0, i_in.measured_lux});
                end
            end
            OP_MUL_I: begin
                n_prod = WIDE_W'(signed'({1'b0, r_ki}) * r_e);
            end
            OP_ACC_I: begin
                // arithmetic shift rounds toward minus infinity
                n_integ = sat32(WIDE_W'(r_integ) + (r_prod >>> I_SHIFT));
            end
            OP_MUL_P: begin
                n_prod = WIDE_W'(signed'({1'b0, r_kp}) * r_e);
            end
            OP_SHIFT_P: begin
                n_p = P_W'(r_prod >>> P_SHIFT);
            end
            OP_FB_SUM: begin
                n_ufb = sat32(WIDE_W'(r_p) + WIDE_W'(r_integ));
            end
            OP_FF_SETUP: begin
                if (w_diff <= 0) begin
                    n_uff = '0;
                end else begin
                    n_uff = DUTY_W'(DUTY_FULL);
                end
                n_quo = {w_diff[LUX_W-1:0], {FF_SHIFT{1'b0}}};
                n_rem = '0;
                n_cnt = CNT_W'(DIV_BITS);
            end
            OP_DIV_STEP: begin
                n_rem = w_trial_ge ? LUX_W'(w_trial - {1'b0, r_lpp}) : w_trial[LUX_W-1:0];
                n_quo = {r_quo[DIV_BITS-2:0], w_trial_ge};
                n_cnt = r_cnt - CNT_W'(1);
            end
            OP_FF_CLAMP: begin
                n_uff = (r_quo > DIV_BITS'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                      : r_quo[DUTY_W-1:0];
            end
            OP_SUM: begin
                n_u   = w_sum;
                n_sat = w_sum_sat;
            end
            OP_AW_BOUND: begin
                // limit that the integral may reach so the output just meets the bound
                n_hi = (r_u > FULL_U);
                if (r_u > FULL_U) begin
                    n_bound = FULL_U - w_ff_s - w_p_s;
                end else begin
                    n_bound = -w_ff_s - w_p_s;
                end
            end
            OP_AW_CLAMP: begin
                if (r_hi) begin
                    n_integ = sat32(WIDE_W'((w_integ_s > r_bound) ? r_bound : w_integ_s));
                end else begin
                    n_integ = sat32(WIDE_W'((w_integ_s < r_bound) ? r_bound : w_integ_s));
                end
            end
            OP_RESUM: begin
                // saturation flag keeps its pre-clamp value
                n_u = w_sum;
            end
            OP_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_u < 0) begin
                        n_o_duty = '0;
                    end else if (r_u > FULL_U) begin
                        n_o_duty = DUTY_W'(DUTY_FULL);
                    end else begin
                        n_o_duty = r_u[DUTY_W-1:0];
                    end
                    n_o_err   = r_e;
                    n_o_fb    = r_ufb;
                    n_o_ff    = r_uff;
                    n_o_integ = r_integ;
                    n_o_sat   = r_sat;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state, integral and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= STEP_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_ref_occ   <= '0;
            r_ref_unocc <= '0;
            r_bg        <= '0;
            r_lpp       <= LUX_W'(LPP_RESET);
            r_mode      <= MODE_W'(MODE_RESET);
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROP_GAIN:   r_kp        <= i_cfg_data[KP_W-1:0];
                    CFG_INTEG_GAIN:  r_ki        <= i_cfg_data[KI_W-1:0];
                    CFG_REF_OCC:     r_ref_occ   <= i_cfg_data[LUX_W-1:0];
                    CFG_REF_UNOCC:   r_ref_unocc <= i_cfg_data[LUX_W-1:0];
                    CFG_BACKGROUND:  r_bg        <= i_cfg_data[LUX_W-1:0];
                    CFG_LUX_PER_PCT: r_lpp       <= i_cfg_data[LUX_W-1:0];
                    CFG_MODE_FLAGS:  r_mode      <= i_cfg_data[MODE_W-1:0];
                    default: begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_e       <= n_e;
        r_prod    <= n_prod;
        r_p       <= n_p;
        r_ufb     <= n_ufb;
        r_uff     <= n_uff;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_u       <= n_u;
        r_sat     <= n_sat;
        r_bound   <= n_bound;
        r_hi      <= n_hi;
        r_o_duty  <= n_o_duty;
        r_o_err   <= n_o_err;
        r_o_fb    <= n_o_fb;
        r_o_ff    <= n_o_ff;
        r_o_integ <= n_o_integ;
        r_o_sat   <= n_o_sat;
    end

    // Divider never runs with an exhausted bit count
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == STEP_DIV) |-> (r_cnt != '0))
        else $error("divider step with zero bit count");

    // Leaving the emit step lands a result and returns to idle
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pc == STEP_OUT) && w_out_free) |=> (o_out.valid && (r_pc == STEP_IDLE)))
        else $error("emit step did not produce a result");

    // Duty and feedforward stay within full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.duty_out <= DUTY_W'(DUTY_FULL))
                         && (o_out.feedforward_drive <= DUTY_W'(DUTY_FULL))))
        else $error("duty or feedforward above full scale");

    // No new input while a transaction is still in the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc != STEP_IDLE) |-> !i_in.ready)
        else $error("input ready while busy");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the lamp PI controller with feedforward and anti-windup.
// Uses pifa_pkg, pifa_in_if, pifa_out_if and pi_feedforward_antiwindup_ctrl.
// A directed table of control ticks is followed by randomized register settings.
`timescale 1ns / 1ps

module tb_top;
    import pifa_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_TICKS   = 650;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int REPORT_LIMIT   = 10;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 3'd7;

    // Mode flag masks
    localparam logic [MODE_W-1:0] M_FB  = MODE_W'(1 << MODE_FB);
    localparam logic [MODE_W-1:0] M_FF  = MODE_W'(1 << MODE_FF);
    localparam logic [MODE_W-1:0] M_AW  = MODE_W'(1 << MODE_AW);
    localparam logic [MODE_W-1:0] M_OCC = MODE_W'(1 << MODE_OCC);

    localparam longint S32_TOP = 64'sd2147483647;
    localparam longint S32_BOT = -64'sd2147483648;

    // Input styles of the random phases
    localparam int STYLE_UNIFORM = 0;
    localparam int STYLE_NEAR    = 1;
    localparam int STYLE_PUSH_UP = 2;
    localparam int STYLE_PUSH_DN = 3;

    typedef struct packed {
        logic [DUTY_W-1:0]         duty;
        logic signed [ERR_W-1:0]   err;
        logic signed [DRIVE_W-1:0] fb;
        logic [DUTY_W-1:0]         ff;
        logic signed [DRIVE_W-1:0] integ;
        logic                      sat;
    } t_tick_result;

    typedef enum bit {ROW_WRITE, ROW_TICK} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [LUX_W-1:0]       meas;
        logic [LUX_W-1:0]       pred;
        logic                   known;
        t_tick_result           res;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pifa_in_if  in_ch ();
    pifa_out_if out_ch ();

    pi_feedforward_antiwindup_ctrl DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the controller registers and the integral
    logic [KP_W-1:0]   kp_reg        = '0;
    logic [KI_W-1:0]   ki_reg        = '0;
    logic [LUX_W-1:0]  ref_occ_reg   = '0;
    logic [LUX_W-1:0]  ref_unocc_reg = '0;
    logic [LUX_W-1:0]  bg_reg        = '0;
    logic [LUX_W-1:0]  lpp_reg       = LUX_W'(LPP_RESET);
    logic [MODE_W-1:0] mode_reg      = MODE_W'(MODE_RESET);
    longint            integ_state   = 0;

    t_tick_result duty_expect_q[$];
    t_stim_row    directed_rows[$];

    int  mismatches     = 0;
    int  ticks_sent     = 0;
    int  directed_ticks = 0;
    int  results_seen   = 0;
    int  sat_results    = 0;
    int  aw_clamp_ticks = 0;
    int  settings_used  = 0;
    int  quiet_cycles   = 0;
    int  rx_hold        = 0;
    bit  rx_steady      = 1'b0;
    bit  cfg_pending    = 1'b0;

    t_tick_result want, seen;

    function automatic longint clip_s32(input longint v);
        if (v > S32_TOP) return S32_TOP;
        if (v < S32_BOT) return S32_BOT;
        return v;
    endfunction

    function automatic longint bound_to(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the shadow integral by one tick and form the expected result
    function automatic t_tick_result control_law(input logic [LUX_W-1:0] meas,
                                                 input logic [LUX_W-1:0] pred);
        longint e, p, ufb, uff, ff_used, u, diff, ref_lux, limit;
        bit fb_on, ff_on, aw_on, sat;
        t_tick_result r;
        fb_on = mode_reg[MODE_FB];
        ff_on = mode_reg[MODE_FF];
        aw_on = mode_reg[MODE_AW];

        e = longint'(pred) - longint'(meas);
        integ_state = clip_s32(integ_state + ((longint'(ki_reg) * e) >>> I_SHIFT));
        p   = (longint'(kp_reg) * e) >>> P_SHIFT;
        ufb = clip_s32(p + integ_state);

        // Feedforward from the selected reference over the plant gain
        ref_lux = mode_reg[MODE_OCC] ? longint'(ref_occ_reg) : longint'(ref_unocc_reg);
        diff    = ref_lux - longint'(bg_reg);
        if (diff <= 0)
            uff = 0;
        else if (lpp_reg == 0)
            uff = DUTY_FULL;
        else
            uff = bound_to((diff <<< FF_SHIFT) / longint'(lpp_reg), 0, DUTY_FULL);

        ff_used = ff_on ? uff : 0;
        u   = (fb_on ? ufb : 0) + ff_used;
        sat = (u > DUTY_FULL) || (u < 0);

        // Pull the integral back so the enabled sum just meets the violated limit
        if (aw_on && sat && ki_reg != 0) begin
            aw_clamp_ticks++;
            if (u > DUTY_FULL) begin
                limit = DUTY_FULL - ff_used - p;
                if (integ_state > limit) integ_state = limit;
            end else begin
                limit = 0 - ff_used - p;
                if (integ_state < limit) integ_state = limit;
            end
            integ_state = clip_s32(integ_state);
            ufb = clip_s32(p + integ_state);
            u   = (fb_on ? ufb : 0) + ff_used;
        end
        u = bound_to(u, 0, DUTY_FULL);

        r.duty  = DUTY_W'(u);
        r.err   = ERR_W'(e);
        r.fb    = DRIVE_W'(ufb);
        r.ff    = DUTY_W'(uff);
        r.integ = DRIVE_W'(integ_state);
        r.sat   = sat;
        return r;
    endfunction

    // Result with both gains at zero: only duty, error and feedforward move
    function automatic t_tick_result known_result(input int duty, input int err, input int ff);
        t_tick_result r;
        r       = '0;
        r.duty  = DUTY_W'(duty);
        r.err   = ERR_W'(err);
        r.ff    = DUTY_W'(ff);
        return r;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap(input bit steady);
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned top,
                                                          input int unsigned typical);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 1) return '0;
        if (r < 2) return CFG_DATA_W'(top);
        if (r < 5) return CFG_DATA_W'($urandom_range(0, top));
        return CFG_DATA_W'($urandom_range(0, typical));
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick(input int meas, input int pred);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_TICK;
        row.meas = LUX_W'(meas);
        row.pred = LUX_W'(pred);
        directed_rows.push_back(row);
    endfunction

    function automatic void add_known(input int meas, input int pred, input t_tick_result res);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_TICK;
        row.meas  = LUX_W'(meas);
        row.pred  = LUX_W'(pred);
        row.known = 1'b1;
        row.res   = res;
        directed_rows.push_back(row);
    endfunction

    // Write one register; hold the enable high so back-to-back writes stay one per edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        cfg_pending = 1'b1;
        case (idx)
            CFG_PROP_GAIN:   kp_reg        = data[KP_W-1:0];
            CFG_INTEG_GAIN:  ki_reg        = data[KI_W-1:0];
            CFG_REF_OCC:     ref_occ_reg   = data[LUX_W-1:0];
            CFG_REF_UNOCC:   ref_unocc_reg = data[LUX_W-1:0];
            CFG_BACKGROUND:  bg_reg        = data[LUX_W-1:0];
            CFG_LUX_PER_PCT: lpp_reg       = data[LUX_W-1:0];
            CFG_MODE_FLAGS:  mode_reg      = data[MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid and the write enable, wait out every pending result, then idle a bit
    task automatic settle();
        in_ch.valid <= 1'b0;
        if (cfg_pending) begin
            i_cfg_we    <= 1'b0;
            cfg_pending = 1'b0;
        end
        while (duty_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offer one control tick; queue its expected result once the transaction is taken
    task automatic drive_tick(input logic [LUX_W-1:0] meas, input logic [LUX_W-1:0] pred,
                              input bit known, input t_tick_result known_res);
        t_tick_result predicted;
        int gap;
        if (cfg_pending) begin
            i_cfg_we    <= 1'b0;
            cfg_pending = 1'b0;
        end
        in_ch.valid         <= 1'b1;
        in_ch.measured_lux  <= meas;
        in_ch.predicted_lux <= pred;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = control_law(meas, pred);
        duty_expect_q.push_back(known ? known_res : predicted);
        ticks_sent++;
        // Keep valid high across back-to-back transactions; lower it only for a gap
        gap = pick_gap(rx_steady);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Result side: randomize ready and check each result transaction in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_hold      <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.duty  = out_ch.duty_out;
                seen.err   = out_ch.error_value;
                seen.fb    = out_ch.feedback_drive;
                seen.ff    = out_ch.feedforward_drive;
                seen.integ = out_ch.integral_value;
                seen.sat   = out_ch.was_saturated;
                results_seen++;
                if (seen.sat) sat_results++;
                if (duty_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing expected", results_seen);
                end else begin
                    want = duty_expect_q.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("result %0d mismatch (expected / actual):", results_seen);
                            $display("  duty %0d / %0d  err %0d / %0d  ff %0d / %0d",
                                     want.duty, seen.duty, want.err, seen.err,
                                     want.ff, seen.ff);
                            $display("  fb %0d / %0d  integ %0d / %0d  sat %0b / %0b",
                                     want.fb, seen.fb, want.integ, seen.integ,
                                     want.sat, seen.sat);
                        end
                    end
                end
            end
            // Hold ready low during a stall, otherwise maybe start one
            if (rx_hold > 0) begin
                rx_hold      <= rx_hold - 1;
                out_ch.ready <= 1'b0;
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                rx_hold      <= pick_gap(1'b0);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int random_ticks;
        int phase_len;
        int style;
        int m, d, pr;
        bit last_was_tick;
        t_stim_row row;

        random_ticks  = 0;
        last_was_tick = 1'b0;

        // Drive every input to a known value from time zero
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.measured_lux  = '0;
        in_ch.predicted_lux = '0;

        // Directed table. Gains reset to zero, so the first rows read off directly.
        add_known(0, 0, known_result(0, 0, 0));
        add_known(65535, 0, known_result(0, -65535, 0));
        add_known(0, 65535, known_result(0, 65535, 0));
        // Feedforward alone, pinned at full duty by a tiny plant gain
        add_write(CFG_BACKGROUND, 0);
        add_write(CFG_REF_UNOCC, 65535);
        add_write(CFG_LUX_PER_PCT, 1);
        add_known(100, 100, known_result(DUTY_FULL, 0, DUTY_FULL));
        // Zero plant gain with the reference above background
        add_write(CFG_LUX_PER_PCT, 0);
        add_known(200, 100, known_result(DUTY_FULL, -100, DUTY_FULL));
        // Occupied reference below background
        add_write(CFG_BACKGROUND, 65535);
        add_write(CFG_REF_OCC, 100);
        add_write(CFG_MODE_FLAGS, CFG_DATA_W'(M_FF | M_OCC));
        add_known(7, 7, known_result(0, 0, 0));
        // Write to a missing register must change nothing
        add_write(CFG_NO_SUCH_REG, '1);
        add_known(7, 7, known_result(0, 0, 0));
        // Moderate PI plus feedforward, anti-windup off
        add_write(CFG_BACKGROUND, 1000);
        add_write(CFG_REF_OCC, 5000);
        add_write(CFG_LUX_PER_PCT, 256);
        add_write(CFG_PROP_GAIN, 256);
        add_write(CFG_INTEG_GAIN, 1024);
        add_write(CFG_MODE_FLAGS, CFG_DATA_W'(M_FB | M_FF | M_OCC));
        add_tick(5000, 5100);
        add_tick(5000, 4000);
        add_tick(0, 65535);
        add_tick(65535, 0);
        // Same with anti-windup clamping at both limits
        add_write(CFG_MODE_FLAGS, CFG_DATA_W'(M_FB | M_FF | M_AW | M_OCC));
        add_tick(0, 65535);
        add_tick(65535, 0);
        add_tick(3000, 3000);
        // Largest gains
        add_write(CFG_PROP_GAIN, 24'h00_FFFF);
        add_write(CFG_INTEG_GAIN, 24'hFF_FFFF);
        add_tick(0, 65535);
        add_tick(65535, 0);
        add_tick(65535, 65535);
        // Anti-windup with zero integral gain leaves the integral alone
        add_write(CFG_INTEG_GAIN, 0);
        add_tick(0, 65535);
        add_tick(65535, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                if (last_was_tick) settle();
                write_reg(row.idx, row.data);
                last_was_tick = 1'b0;
            end else begin
                drive_tick(row.meas, row.pred, row.known, row.res);
                directed_ticks++;
                last_was_tick = 1'b1;
            end
        end
        settings_used = 1;

        // Random phases: fresh settings, then a burst of ticks in one input style
        while (random_ticks < RANDOM_TICKS) begin
            settle();
            write_reg(CFG_PROP_GAIN,   pick_setting(65535, 2047));
            write_reg(CFG_INTEG_GAIN,  pick_setting(16777215, 4095));
            write_reg(CFG_REF_OCC,     pick_setting(65535, 65535));
            write_reg(CFG_REF_UNOCC,   pick_setting(65535, 65535));
            write_reg(CFG_BACKGROUND,  pick_setting(65535, 32767));
            write_reg(CFG_LUX_PER_PCT, pick_setting(65535, 1024));
            write_reg(CFG_MODE_FLAGS,  CFG_DATA_W'($urandom_range(0, 15)));
            settings_used++;
            rx_steady = ($urandom_range(0, 3) == 0);
            style     = $urandom_range(STYLE_UNIFORM, STYLE_PUSH_DN);
            phase_len = $urandom_range(20, 70);
            for (int k = 0; k < phase_len && random_ticks < RANDOM_TICKS; k++) begin
                case (style)
                    STYLE_NEAR: begin
                        m  = $urandom_range(0, 65535);
                        d  = $urandom_range(0, 400);
                        pr = int'(bound_to(m + d - 200, 0, 65535));
                    end
                    STYLE_PUSH_UP: begin
                        m  = $urandom_range(0, 4000);
                        pr = $urandom_range(30000, 65535);
                    end
                    STYLE_PUSH_DN: begin
                        m  = $urandom_range(30000, 65535);
                        pr = $urandom_range(0, 4000);
                    end
                    default: begin
                        m  = $urandom_range(0, 65535);
                        pr = $urandom_range(0, 65535);
                    end
                endcase
                // Now and then hold off until every pending result is back
                if ($urandom_range(0, 39) == 0) settle();
                drive_tick(LUX_W'(m), LUX_W'(pr), 1'b0, '0);
                random_ticks++;
            end
        end

        // Drain and let the block go quiet
        settle();
        rx_steady = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d control ticks (%0d directed) over %0d register settings",
                 ticks_sent, directed_ticks, settings_used);
        $display("%0d results saturated, %0d ticks went through the anti-windup clamp",
                 sat_results, aw_clamp_ticks);
        if (duty_expect_q.size() != 0)
            $display("%0d expected results never arrived", duty_expect_q.size());
        if (mismatches == 0 && duty_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/pifa_pkg.sv
sv/pifa_in_if.sv
sv/pifa_out_if.sv
sv/pi_feedforward_antiwindup_ctrl.sv
bench/tb_top.sv
